FILE: hw/rtl/pa_pkg.sv
`timescale 1ns / 1ps

package pa_pkg;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_FREE    = 2'd1,
        CMD_ADD_REF = 2'd2,
        CMD_INIT    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        RES_ALLOCATED   = 3'd0,
        RES_EMPTY       = 3'd1,
        RES_RELEASED    = 3'd2,
        RES_DECREMENTED = 3'd3,
        RES_REF_ADDED   = 3'd4,
        RES_REJECTED    = 3'd5,
        RES_INIT_DONE   = 3'd6
    } status_t;

    localparam logic REG_REGION_START = 1'b0;
    localparam logic REG_REGION_END   = 1'b1;

    localparam logic [31:0] REGION_START_RESET = 32'h8000_0000;
    localparam logic [31:0] REGION_END_RESET   = 32'h8800_0000;
    localparam logic [31:0] INDEX_MASK         = 32'h07ff_ffff;
    localparam logic [15:0] REF_MAX            = 16'hffff;

    // controller -> datapath
    typedef struct packed {
        logic load_item;   // input transfer, launch memory reads
        logic exec;        // apply alloc/free/add_ref and load the result
        logic clr_step;    // zero one count entry
        logic init_start;  // empty the list, load the push pointer
        logic push_step;   // push one region page
        logic emit_init;   // load the init-done result
    } ctrl_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic push_more;
        logic out_free;
    } stat_t;

endpackage

FILE: hw/rtl/pa_ctrl.sv
`timescale 1ns / 1ps

module pa_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic [1:0]        s_command,
    input  pa_pkg::stat_t     stat,
    output pa_pkg::ctrl_t     ctrl,
    output logic              s_ready
);

    typedef enum logic [2:0] {
        S_RST_CLR,
        S_IDLE,
        S_EXEC,
        S_INIT_CLR,
        S_INIT_PUSH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        ctrl       = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_RST_CLR: begin
                ctrl.clr_step = 1'b1;
                if (stat.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctrl.load_item = 1'b1;
                    if (s_command == pa_pkg::CMD_INIT) begin
                        ctrl.init_start = 1'b1;
                        state_next      = S_INIT_CLR;
                    end else begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                if (stat.out_free) begin
                    ctrl.exec  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_INIT_CLR: begin
                ctrl.clr_step = 1'b1;
                if (stat.clr_last) begin
                    state_next = S_INIT_PUSH;
                end
            end
            S_INIT_PUSH: begin
                if (stat.push_more) begin
                    ctrl.push_step = 1'b1;
                end else if (stat.out_free) begin
                    ctrl.emit_init = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_RST_CLR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_RST_CLR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hw/rtl/pa_datapath.sv
`timescale 1ns / 1ps

module pa_datapath #(
    parameter int NUM_PAGES  = 32768,
    parameter int PAGE_BYTES = 4096
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  pa_pkg::ctrl_t     ctrl,
    output pa_pkg::stat_t     stat,
    input  logic [1:0]        s_command,
    input  logic [31:0]       s_page_address,
    input  logic              cfg_valid,
    input  logic              cfg_index,
    input  logic [31:0]       cfg_data,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [31:0]       m_result_address,
    output logic [2:0]        m_status,
    output logic [15:0]       m_ref_count
);

    localparam int PB_W   = $clog2(PAGE_BYTES);
    localparam int PAGE_W = $clog2(NUM_PAGES);

    function automatic logic [PAGE_W-1:0] page_idx(input logic [31:0] a);
        logic [31:0] m;
        m = (a & pa_pkg::INDEX_MASK) >> PB_W;
        return m[PAGE_W-1:0];
    endfunction

    logic [15:0]        refs_mem [NUM_PAGES];
    logic [32:0]        link_mem [NUM_PAGES];

    logic [31:0]        start_reg;
    logic [31:0]        end_reg;
    logic [32:0]        head_reg;
    logic [32:0]        head_next;
    logic [PAGE_W-1:0]  clr_cnt_reg;
    logic [32:0]        p_reg;
    pa_pkg::cmd_t       cmd_reg;
    logic [31:0]        addr_reg;
    logic [15:0]        refs_rd_reg;
    logic [32:0]        link_rd_reg;

    logic               m_valid_reg;
    logic [31:0]        m_addr_reg;
    pa_pkg::status_t    m_status_reg;
    logic [15:0]        m_count_reg;

    logic               refs_we;
    logic [PAGE_W-1:0]  refs_wa;
    logic [15:0]        refs_wd;
    logic               link_we;
    logic [PAGE_W-1:0]  link_wa;
    logic [31:0]        res_addr;
    pa_pkg::status_t    res_status;
    logic [15:0]        res_count;
    logic               load_out;
    logic               reject;
    logic [32:0]        start_up;
    logic [PAGE_W-1:0]  item_idx;

    assign item_idx = page_idx(addr_reg);
    assign start_up = ({1'b0, start_reg} + 33'(PAGE_BYTES - 1)) & ~33'(PAGE_BYTES - 1);
    assign reject   = (addr_reg[PB_W-1:0] != '0) || (addr_reg < start_reg)
                      || (addr_reg >= end_reg);
    assign load_out = ctrl.exec || ctrl.emit_init;

    assign stat.clr_last  = (clr_cnt_reg == PAGE_W'(NUM_PAGES - 1));
    assign stat.push_more = ({1'b0, p_reg} + 34'(PAGE_BYTES)) <= {2'b00, end_reg};
    assign stat.out_free  = !m_valid_reg || m_ready;

    always_comb begin
        refs_we    = 1'b0;
        refs_wa    = clr_cnt_reg;
        refs_wd    = '0;
        link_we    = 1'b0;
        link_wa    = item_idx;
        head_next  = head_reg;
        res_addr   = '0;
        res_status = pa_pkg::RES_INIT_DONE;
        res_count  = '0;
        if (ctrl.clr_step) begin
            refs_we = 1'b1;
        end
        if (ctrl.init_start) begin
            head_next = '0;
        end
        if (ctrl.push_step) begin
            link_we   = 1'b1;
            link_wa   = page_idx(p_reg[31:0]);
            head_next = {1'b1, p_reg[31:0]};
        end
        if (ctrl.exec) begin
            case (cmd_reg)
                pa_pkg::CMD_ALLOC: begin
                    if (head_reg[32]) begin
                        refs_we    = 1'b1;
                        refs_wa    = page_idx(head_reg[31:0]);
                        refs_wd    = 16'd1;
                        head_next  = link_rd_reg;
                        res_addr   = head_reg[31:0];
                        res_status = pa_pkg::RES_ALLOCATED;
                        res_count  = 16'd1;
                    end else begin
                        res_status = pa_pkg::RES_EMPTY;
                    end
                end
                pa_pkg::CMD_FREE: begin
                    if (reject) begin
                        res_status = pa_pkg::RES_REJECTED;
                    end else if (refs_rd_reg > 16'd1) begin
                        refs_we    = 1'b1;
                        refs_wa    = item_idx;
                        refs_wd    = refs_rd_reg - 16'd1;
                        res_status = pa_pkg::RES_DECREMENTED;
                        res_count  = refs_rd_reg - 16'd1;
                    end else begin
                        refs_we    = 1'b1;
                        refs_wa    = item_idx;
                        link_we    = 1'b1;
                        head_next  = {1'b1, addr_reg};
                        res_status = pa_pkg::RES_RELEASED;
                    end
                end
                pa_pkg::CMD_ADD_REF: begin
                    refs_we    = 1'b1;
                    refs_wa    = item_idx;
                    refs_wd    = (refs_rd_reg == pa_pkg::REF_MAX) ? refs_rd_reg
                                                                  : refs_rd_reg + 16'd1;
                    res_status = pa_pkg::RES_REF_ADDED;
                    res_count  = refs_wd;
                end
                default: begin
                    res_status = pa_pkg::RES_INIT_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (refs_we) begin
            refs_mem[refs_wa] <= refs_wd;
        end
        if (ctrl.load_item) begin
            refs_rd_reg <= refs_mem[page_idx(s_page_address)];
        end
    end

    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_mem[link_wa] <= head_reg;
        end
        if (ctrl.load_item) begin
            link_rd_reg <= link_mem[page_idx(head_reg[31:0])];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg   <= pa_pkg::REGION_START_RESET;
            end_reg     <= pa_pkg::REGION_END_RESET;
            head_reg    <= '0;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    pa_pkg::REG_REGION_START: start_reg <= cfg_data;
                    pa_pkg::REG_REGION_END:   end_reg   <= cfg_data;
                    default: ;
                endcase
            end
            head_reg <= head_next;
            if (ctrl.clr_step) begin
                clr_cnt_reg <= stat.clr_last ? '0 : clr_cnt_reg + 1'b1;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_item) begin
            cmd_reg  <= pa_pkg::cmd_t'(s_command);
            addr_reg <= s_page_address;
        end
        if (ctrl.init_start) begin
            p_reg <= start_up;
        end else if (ctrl.push_step) begin
            p_reg <= p_reg + 33'(PAGE_BYTES);
        end
        if (load_out) begin
            m_addr_reg   <= res_addr;
            m_status_reg <= res_status;
            m_count_reg  <= res_count;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_result_address = m_addr_reg;
    assign m_status         = m_status_reg;
    assign m_ref_count      = m_count_reg;

endmodule

FILE: hw/rtl/page_allocator_with_ref_counts.sv
`timescale 1ns / 1ps

// Page frame allocator: LIFO linked free list plus a 16-bit reference count
// per page, both held in single-port-write, registered-read memories of
// NUM_PAGES entries (NUM_PAGES and PAGE_BYTES are powers of two). Alloc, free
// and add_ref each have a transfer cycle that launches the count and link
// reads and an S_EXEC cycle that applies the update and loads the result
// register; S_EXEC is held for as long as the previous result is still
// waiting for m_ready. Init takes the transfer cycle, zeroes the count
// memory in S_INIT_CLR, pushes one region page per cycle in S_INIT_PUSH,
// then loads the result (held the same way). After reset the count memory
// is cleared in S_RST_CLR with s_ready low; configuration writes are
// taken at any time and must be made while idle.

module page_allocator_with_ref_counts #(
    parameter int NUM_PAGES  = 32768,
    parameter int PAGE_BYTES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [31:0] s_page_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_result_address,
    output logic [2:0]  m_status,
    output logic [15:0] m_ref_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    pa_pkg::ctrl_t ctrl;
    pa_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    pa_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_command (s_command),
        .stat      (stat),
        .ctrl      (ctrl),
        .s_ready   (s_ready)
    );

    pa_datapath #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .ctrl             (ctrl),
        .stat             (stat),
        .s_command        (s_command),
        .s_page_address   (s_page_address),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_address (m_result_address),
        .m_status         (m_status),
        .m_ref_count      (m_ref_count)
    );

    // one item in flight
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is in flight");

    // a result appears only out of a busy cycle
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result loaded while idle");

    // only alloc returns an address
    a_addr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != pa_pkg::RES_ALLOCATED) |-> m_result_address == 32'd0)
        else $error("nonzero address on a non-alloc result");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= pa_pkg::RES_INIT_DONE)
        else $error("status code out of range");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int NUM_PAGES      = 32768;
    localparam int PAGE_BYTES     = 4096;
    localparam int WATCHDOG_LIMIT = 300000;

    typedef struct {
        logic [31:0]      addr;
        pa_pkg::status_t  st;
        logic [15:0]      cnt;
    } alloc_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command = pa_pkg::CMD_ALLOC;
    logic [31:0] s_page_address = 32'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_result_address;
    logic [2:0]  m_status;
    logic [15:0] m_ref_count;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = pa_pkg::REG_REGION_START;
    logic [31:0] cfg_data = 32'd0;

    page_allocator_with_ref_counts u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_page_address   (s_page_address),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_address (m_result_address),
        .m_status         (m_status),
        .m_ref_count      (m_ref_count),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #2 aclk = ~aclk;

    // allocator state as the block should hold it
    logic [31:0]   region_start_q = pa_pkg::REGION_START_RESET;
    logic [31:0]   region_end_q   = pa_pkg::REGION_END_RESET;
    bit            head_valid;
    bit [31:0]     head_addr;
    bit            link_valid [NUM_PAGES];
    bit [31:0]     link_addr  [NUM_PAGES];
    bit [15:0]     ref_table  [NUM_PAGES];

    alloc_result_t pending_results [$];
    alloc_result_t want;
    int            errors = 0;
    int            idle_cycles = 0;
    bit            fast_mode = 1'b0;
    int            ready_hold = 0;

    function automatic logic [14:0] frame_index(logic [31:0] a);
        logic [31:0] m;
        m = a & pa_pkg::INDEX_MASK;
        return m[26:12];
    endfunction

    function automatic void push_frame(logic [31:0] a);
        logic [14:0] i;
        i = frame_index(a);
        link_valid[i] = head_valid;
        link_addr[i]  = head_addr;
        head_valid    = 1'b1;
        head_addr     = a;
    endfunction

    function automatic alloc_result_t predict_page_op(pa_pkg::cmd_t c, logic [31:0] a);
        alloc_result_t r;
        logic [14:0]   i;
        logic [14:0]   j;
        logic [63:0]   p;
        logic [63:0]   top;
        i = frame_index(a);
        r.addr = 32'd0;
        r.st   = pa_pkg::RES_EMPTY;
        r.cnt  = 16'd0;
        case (c)
            pa_pkg::CMD_ALLOC: begin
                if (head_valid) begin
                    j = frame_index(head_addr);
                    r.addr = head_addr;
                    r.st   = pa_pkg::RES_ALLOCATED;
                    r.cnt  = 16'd1;
                    head_valid   = link_valid[j];
                    head_addr    = link_addr[j];
                    ref_table[j] = 16'd1;
                end
            end
            pa_pkg::CMD_FREE: begin
                if (a[11:0] != 12'd0 || a < region_start_q || a >= region_end_q) begin
                    r.st = pa_pkg::RES_REJECTED;
                end else if (ref_table[i] > 16'd1) begin
                    ref_table[i] = ref_table[i] - 16'd1;
                    r.st  = pa_pkg::RES_DECREMENTED;
                    r.cnt = ref_table[i];
                end else begin
                    ref_table[i] = 16'd0;
                    push_frame(a);
                    r.st = pa_pkg::RES_RELEASED;
                end
            end
            pa_pkg::CMD_ADD_REF: begin
                if (ref_table[i] != pa_pkg::REF_MAX)
                    ref_table[i] = ref_table[i] + 16'd1;
                r.st  = pa_pkg::RES_REF_ADDED;
                r.cnt = ref_table[i];
            end
            default: begin
                foreach (ref_table[k])
                    ref_table[k] = 16'd0;
                head_valid = 1'b0;
                p   = (({32'd0, region_start_q} + 64'd4095) >> 12) << 12;
                top = {32'd0, region_end_q};
                while (p + PAGE_BYTES <= top) begin
                    push_frame(p[31:0]);
                    p = p + PAGE_BYTES;
                end
                r.st = pa_pkg::RES_INIT_DONE;
            end
        endcase
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result checker, predictor and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result transfer with nothing expected: addr %h status %0d count %0d",
                           m_result_address, m_status, m_ref_count);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_result_address !== want.addr) begin
                        $error("result_address: expected %h, got %h", want.addr, m_result_address);
                        errors++;
                    end
                    if (m_status !== want.st) begin
                        $error("status: expected %0d, got %0d", want.st, m_status);
                        errors++;
                    end
                    if (m_ref_count !== want.cnt) begin
                        $error("ref_count: expected %0d, got %0d", want.cnt, m_ref_count);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready)
                pending_results.push_back(predict_page_op(pa_pkg::cmd_t'(s_command),
                                                          s_page_address));
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == pa_pkg::REG_REGION_START)
                    region_start_q = cfg_data;
                else
                    region_end_q = cfg_data;
            end
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (fast_mode) begin
            m_ready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
        end else begin
            m_ready <= ($urandom_range(0, 9) < 7);
            ready_hold = pick_gap();
        end
    end

    task automatic send_item(pa_pkg::cmd_t c, logic [31:0] a);
        int gap;
        gap = fast_mode ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_command      <= c;
        s_page_address <= a;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_region(logic [31:0] rs, logic [31:0] re);
        drain();
        write_reg(pa_pkg::REG_REGION_START, rs);
        write_reg(pa_pkg::REG_REGION_END, re);
    endtask

    task automatic test_after_reset();
        send_item(pa_pkg::CMD_ALLOC, 32'h0000_0000);    // empty list
        send_item(pa_pkg::CMD_FREE, 32'h8000_0001);     // misaligned
        send_item(pa_pkg::CMD_FREE, 32'h7fff_f000);     // below region
        send_item(pa_pkg::CMD_FREE, 32'h8800_0000);     // at region end
        send_item(pa_pkg::CMD_ADD_REF, 32'hffff_ffff);  // no range check
        send_item(pa_pkg::CMD_FREE, 32'h8000_0000);
        send_item(pa_pkg::CMD_ALLOC, 32'hffff_ffff);
        send_item(pa_pkg::CMD_ADD_REF, 32'h8000_0000);
        send_item(pa_pkg::CMD_FREE, 32'h8000_0000);
        send_item(pa_pkg::CMD_FREE, 32'h8000_0000);
        send_item(pa_pkg::CMD_FREE, 32'h8000_0000);     // double free
        send_item(pa_pkg::CMD_ALLOC, 32'h0000_0000);
    endtask

    task automatic test_init_full_region();
        send_item(pa_pkg::CMD_INIT, 32'h1234_5678);     // list not empty here
        send_item(pa_pkg::CMD_ALLOC, 32'h0000_0000);
        send_item(pa_pkg::CMD_ALLOC, 32'h0000_0000);
        send_item(pa_pkg::CMD_FREE, 32'h87ff_f000);
        send_item(pa_pkg::CMD_ALLOC, 32'h0000_0000);
    endtask

    task automatic test_wrap_region();
        set_region(32'h0000_0000, 32'h0804_0000);
        send_item(pa_pkg::CMD_INIT, 32'h0000_0000);
        send_item(pa_pkg::CMD_ALLOC, 32'h0000_0000);
        send_item(pa_pkg::CMD_ALLOC, 32'h0000_0000);
        send_item(pa_pkg::CMD_ADD_REF, 32'h0003_f000);  // aliases the first page
        send_item(pa_pkg::CMD_FREE, 32'h0803_f000);
        send_item(pa_pkg::CMD_FREE, 32'h0003_f000);
        send_item(pa_pkg::CMD_ALLOC, 32'h0000_0000);
    endtask

    // back-to-back count updates on one page through two aliases
    task automatic test_ref_counts();
        drain();
        fast_mode = 1'b1;
        for (int n = 0; n < 32; n++)
            send_item(pa_pkg::CMD_ADD_REF, n[0] ? 32'h0800_1000 : 32'h0000_1000);
        repeat (3) send_item(pa_pkg::CMD_FREE, 32'h0000_1000);
        drain();
        fast_mode = 1'b0;
    endtask

    task automatic test_empty_regions();
        set_region(32'hffff_f001, 32'hffff_ffff);
        send_item(pa_pkg::CMD_INIT, 32'h0000_0000);
        send_item(pa_pkg::CMD_ALLOC, 32'h0000_0000);
        send_item(pa_pkg::CMD_FREE, 32'hffff_f000);
        set_region(32'h0000_1000, 32'h0000_0000);
        send_item(pa_pkg::CMD_INIT, 32'h0000_0000);
        send_item(pa_pkg::CMD_ALLOC, 32'h0000_0000);
        send_item(pa_pkg::CMD_FREE, 32'h0000_1000);
    endtask

    task automatic run_phase(int n_items, int alloc_pct, bit wide, bit fast);
        logic [31:0]  lo;
        logic [31:0]  page;
        logic [31:0]  addr;
        int           np;
        int           k;
        pa_pkg::cmd_t c;
        np = $urandom_range(16, 64);
        if (wide) begin
            lo = $urandom_range(0, 32'h000f_ff80) << 12;
            set_region(32'h0000_0000, 32'hffff_ffff);
        end else begin
            lo = $urandom_range(1, 32'h000f_ff00) << 12;
            set_region(lo - $urandom_range(0, 4095), lo + np * PAGE_BYTES + $urandom_range(0, 4095));
        end
        fast_mode = fast;
        if (!wide)
            send_item(pa_pkg::CMD_INIT, $urandom);
        repeat (n_items) begin
            page = lo + ($urandom_range(0, np - 1) << 12);
            case ($urandom_range(0, 9))
                0:       addr = $urandom;
                1:       addr = page | $urandom_range(1, 4095);
                default: addr = page;
            endcase
            k = $urandom_range(0, 99);
            if (!wide && $urandom_range(0, 999) < 4)
                c = pa_pkg::CMD_INIT;
            else if (k < alloc_pct)
                c = pa_pkg::CMD_ALLOC;
            else if (k[0])
                c = pa_pkg::CMD_FREE;
            else
                c = pa_pkg::CMD_ADD_REF;
            send_item(c, addr);
            if ($urandom_range(0, 99) == 0)
                drain();
        end
        drain();
        fast_mode = 1'b0;
    endtask

    task automatic test_random_traffic();
        run_phase(280, 35, 1'b0, 1'b0);
        run_phase(280, 60, 1'b0, 1'b0);
        run_phase(280, 40, 1'b1, 1'b0);
        run_phase(280, 35, 1'b0, 1'b1);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_after_reset();
        test_init_full_region();
        test_wrap_region();
        test_ref_counts();
        test_empty_regions();
        test_random_traffic();
        drain();
        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/pa_pkg.sv
hw/rtl/pa_ctrl.sv
hw/rtl/pa_datapath.sv
hw/rtl/page_allocator_with_ref_counts.sv
tb/sv/tb.sv
